/* rtl/core/dnts_pkg.sv */
package dnts_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = 6;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 7;
    localparam int RECT_W      = 4 * COORD_W;

    localparam logic [COORD_W-1:0] KEY_START = 16'hFFFF;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_NAV  = 1'b1;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   entry_index;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] bottom_y;
        logic [IDX_W-1:0]   current_index;
        logic [1:0]         direction;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             found;
    } t_out_rsp;

    typedef struct packed {
        logic load_wr;
        logic nav_start;
        logic cur_capture;
        logic scan_step;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

    function automatic logic [COORD_W-1:0] center(input logic [COORD_W-1:0] lo,
                                                  input logic [COORD_W-1:0] hi);
        logic [COORD_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[COORD_W:1];
    endfunction

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/core/directional_nearest_target_search.sv */
// Directional nearest-target search. A load request (mode 0) writes one rectangle into
// the table and gives no result. A navigate request (mode 1) gives one result: it is
// accepted, the current entry is read, the compare pass walks the first n entries, where n
// is entry_count saturated to the table depth, or 0 when current_index lies outside the
// table, and the result register is loaded. The compare pass is drawn out by the
// registered table read: the last entry is judged in the cycle after its address goes
// out, and the pass ends in the cycle after that. The length of a search is set by the
// single read port of the rectangle table, which the compare pass walks one entry per
// cycle. The input is stalled while a search runs, and the search also waits in its last
// state for as long as an earlier result sits stalled in the output register. Once loaded,
// a finished result waits in the output register while the next request is taken.
module directional_nearest_target_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dnts_pkg::t_in_req          i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dnts_pkg::t_out_rsp         o_out_rsp,
    input  logic                       i_cfg_we,
    input  logic [dnts_pkg::CFG_W-1:0] i_cfg_wdata
);

    dnts_pkg::t_cmd    w_cmd;
    dnts_pkg::t_status w_status;

    dnts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_req.mode),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    dnts_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

/* rtl/core/dnts_ram.sv */
module dnts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dnts_ctrl.sv */
module dnts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    input  dnts_pkg::t_status i_status,
    output dnts_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CUR  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode == dnts_pkg::MODE_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.nav_start = 1'b1;
                        n_state = S_CUR;
                    end
                end
            end
            S_CUR: begin
                o_cmd.cur_capture = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/core/dnts_datapath.sv */
module dnts_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dnts_pkg::t_in_req             i_in_req,
    input  logic                          i_cfg_we,
    input  logic [dnts_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  dnts_pkg::t_cmd                i_cmd,
    output dnts_pkg::t_status             o_status,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output dnts_pkg::t_out_rsp            o_out_rsp
);

    localparam int AW = dnts_pkg::ADDR_W;
    localparam int CW = dnts_pkg::CNT_W;
    localparam int KW = dnts_pkg::COORD_W;
    localparam int IW = dnts_pkg::IDX_W;

    logic [dnts_pkg::CFG_W-1:0] r_count;

    logic [IW-1:0] r_cur;
    logic [1:0]    r_dir;
    logic          r_cur_ok;
    logic [KW-1:0] r_cx;
    logic [KW-1:0] r_cy;
    logic [CW-1:0] r_limit;
    logic [CW-1:0] r_addr;
    logic          r_pv;
    logic [CW-1:0] r_pidx;
    logic [KW-1:0] r_best_main;
    logic [KW-1:0] r_best_cross;
    logic [IW-1:0] r_best_idx;
    logic          r_found;
    logic          r_out_valid;
    dnts_pkg::t_out_rsp r_out;

    logic                       w_we;
    logic [AW-1:0]              w_raddr;
    logic [dnts_pkg::RECT_W-1:0] w_wdata;
    logic [dnts_pkg::RECT_W-1:0] w_rdata;
    logic [CW-1:0]              w_sat_count;
    logic                       w_issue;
    logic [KW-1:0]              w_ex;
    logic [KW-1:0]              w_ey;
    logic [KW-1:0]              w_dx;
    logic [KW-1:0]              w_dy;
    logic [KW-1:0]              w_main;
    logic [KW-1:0]              w_cross;
    logic                       w_ok;
    logic                       w_better;
    logic                       w_take;

    // Loads beyond the table are dropped.
    assign w_we    = i_cmd.load_wr && (int'(i_in_req.entry_index) < dnts_pkg::MAX_ENTRIES);
    assign w_wdata = {i_in_req.bottom_y, i_in_req.top_y, i_in_req.right_x, i_in_req.left_x};
    assign w_raddr = i_cmd.nav_start ? AW'(i_in_req.current_index) : AW'(r_addr);

    dnts_ram #(
        .WIDTH (dnts_pkg::RECT_W),
        .DEPTH (dnts_pkg::MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in_req.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sat_count = (int'(r_count) > dnts_pkg::MAX_ENTRIES) ?
                         CW'(dnts_pkg::MAX_ENTRIES) : CW'(r_count);

    assign w_issue = i_cmd.scan_step && (r_addr < r_limit);

    // Candidate evaluation on the entry read in the previous cycle.
    always_comb begin
        w_ex = dnts_pkg::center(w_rdata[KW-1:0], w_rdata[2*KW-1:KW]);
        w_ey = dnts_pkg::center(w_rdata[3*KW-1:2*KW], w_rdata[4*KW-1:3*KW]);
        w_dx = dnts_pkg::absdiff(w_ex, r_cx);
        w_dy = dnts_pkg::absdiff(w_ey, r_cy);
        case (r_dir)
            dnts_pkg::DIR_LEFT:  w_ok = (w_ex < r_cx);
            dnts_pkg::DIR_RIGHT: w_ok = (w_ex > r_cx);
            dnts_pkg::DIR_UP:    w_ok = (w_ey < r_cy);
            default:             w_ok = (w_ey > r_cy);
        endcase
        w_main  = r_dir[1] ? w_dy : w_dx;
        w_cross = r_dir[1] ? w_dx : w_dy;
        w_better = (w_main < r_best_main) ||
                   ((w_main == r_best_main) && (w_cross < r_best_cross));
        w_take = i_cmd.scan_step && r_pv && w_ok && w_better &&
                 (int'(r_pidx) != int'(r_cur));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= dnts_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nav_start) begin
            r_cur    <= i_in_req.current_index;
            r_dir    <= i_in_req.direction;
            r_cur_ok <= (int'(i_in_req.current_index) < dnts_pkg::MAX_ENTRIES);
        end
        if (i_cmd.cur_capture) begin
            r_cx         <= dnts_pkg::center(w_rdata[KW-1:0], w_rdata[2*KW-1:KW]);
            r_cy         <= dnts_pkg::center(w_rdata[3*KW-1:2*KW], w_rdata[4*KW-1:3*KW]);
            r_limit      <= r_cur_ok ? w_sat_count : '0;
            r_addr       <= '0;
            r_best_main  <= dnts_pkg::KEY_START;
            r_best_cross <= dnts_pkg::KEY_START;
            r_best_idx   <= r_cur;
            r_found      <= 1'b0;
        end
        if (w_issue) begin
            r_addr <= r_addr + CW'(1);
            r_pidx <= r_addr;
        end
        if (w_take) begin
            r_best_main  <= w_main;
            r_best_cross <= w_cross;
            r_best_idx   <= IW'(r_pidx);
            r_found      <= 1'b1;
        end
        if (i_cmd.res_load) begin
            r_out.chosen_index <= r_best_idx;
            r_out.found        <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cur_capture) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pv <= w_issue;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.scan_done = (r_addr >= r_limit) && !r_pv;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_rsp          = r_out;

endmodule

/* rtl/core/dnts_chk.sv */
module dnts_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input dnts_pkg::t_in_req          i_in_req,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input dnts_pkg::t_out_rsp         o_out_rsp,
    input logic                       i_cfg_we,
    input logic [dnts_pkg::CFG_W-1:0] i_cfg_wdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_rsp))
        else $error("stalled result changed");

    // An accepted navigate request keeps the input stalled while the search runs.
    a_nav_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.mode == dnts_pkg::MODE_NAV) |=> o_in_stall)
        else $error("input taken during a search");

    // A new result only appears at the end of a search.
    a_out_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a search");

    // An empty result also comes only after a compare pass.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && !o_out_rsp.found |-> $past(o_in_stall, 2))
        else $error("empty result outside a search");

endmodule

bind directional_nearest_target_search dnts_chk u_chk (.*);
